// ===== hdl/sph_pkg.sv =====
// shared types, constants and round-constant table for the sponge hash
`timescale 1ns / 1ps

package sph_pkg;

    localparam int LANE_COUNT   = 32;
    localparam int LANE_W       = 64;
    localparam int RC_IDX_W     = 6;
    localparam int RC_DEPTH     = 64;
    localparam int DIGEST_BYTES = 48;
    localparam int DIGEST_WORDS = 6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_LEN = 1'b1;

    localparam logic [8:0] DIGEST_LEN_RESET = 9'd384;

    localparam int unsigned ROW_DEST [8] = '{1, 7, 5, 2, 4, 6, 0, 3};
    localparam int unsigned ROT_A    [8] = '{ 1,  2,  4,  7, 26, 49, 55, 58};
    localparam int unsigned ROT_B    [8] = '{ 3,  5, 15,  9, 46,  6, 19, 47};
    localparam int unsigned ROT_C    [8] = '{14, 23, 17, 12, 13, 50, 56, 61};
    localparam int unsigned ROT_D    [8] = '{36, 60, 24, 40, 37, 25, 57, 28};

    typedef logic [LANE_W-1:0] t_lanes [LANE_COUNT];
    typedef logic [LANE_W-1:0] t_rc_table [RC_DEPTH];

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_PERM,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        AFT_NONE,
        AFT_PAD,
        AFT_SQUEEZE
    } t_after;

    // rotate left by a constant amount
    function automatic logic [LANE_W-1:0] rol64(input logic [LANE_W-1:0] v,
                                                input int unsigned n);
        int unsigned m;
        m = n % 64;
        if (m == 0) begin
            return v;
        end
        return (v << m) | (v >> (64 - m));
    endfunction

    // round constants, worked out at elaboration
    function automatic t_rc_table build_rc();
        t_rc_table t;
        logic [LANE_W-1:0] v;
        for (int i = 0; i < RC_DEPTH; i++) begin
            v = 64'h9e3779b97f4a7c15 ^ 64'(i);
            v = v ^ (v >> 30);
            v = v * 64'hbf58476d1ce4e5b9;
            v = v ^ (v >> 27);
            v = v * 64'h94d049bb133111eb;
            v = v ^ (v >> 31);
            t[i] = v;
        end
        return t;
    endfunction

    localparam t_rc_table RC_TABLE = build_rc();

endpackage

// ===== hdl/sph_round.sv =====
// one permutation round over the full 2048-bit state
`timescale 1ns / 1ps

module sph_round (
    input  sph_pkg::t_lanes      i_lanes,
    input  logic [63:0]          i_rc,
    output sph_pkg::t_lanes      o_lanes
);

    sph_pkg::t_lanes y;
    sph_pkg::t_lanes z;
    sph_pkg::t_lanes x;

    always_comb begin
        // nonlinear mix across rows, column by column
        for (int j = 0; j < 4; j++) begin
            y[j]      = i_lanes[j]      ^ (~i_lanes[4 + j]  & i_lanes[8 + j]);
            y[4 + j]  = i_lanes[16 + j] ^ (~i_lanes[8 + j]  & i_lanes[j]);
            y[8 + j]  = i_lanes[12 + j] ^ (~i_lanes[j]      & i_lanes[4 + j]);
            y[12 + j] = ~i_lanes[4 + j] ^ (~i_lanes[16 + j] & ~i_lanes[20 + j]);
            y[16 + j] = i_lanes[8 + j]  ^ (~i_lanes[20 + j] & i_lanes[24 + j]);
            y[20 + j] = i_lanes[20 + j] ^ (~i_lanes[24 + j] & i_lanes[28 + j]);
            y[24 + j] = i_lanes[24 + j] ^ (~i_lanes[28 + j] & i_lanes[12 + j]);
            y[28 + j] = i_lanes[28 + j] ^ (~i_lanes[12 + j] & i_lanes[16 + j]);
        end
        // row permutation
        for (int r = 0; r < 8; r++) begin
            for (int j = 0; j < 4; j++) begin
                z[sph_pkg::ROW_DEST[r] * 4 + j] = y[r * 4 + j];
            end
        end
        // rotate-xor mix inside each row
        for (int r = 0; r < 8; r++) begin
            for (int j = 0; j < 4; j++) begin
                x[r * 4 + j] = z[r * 4 + j]
                    ^ sph_pkg::rol64(z[r * 4 + ((j + 1) % 4)], sph_pkg::ROT_A[r])
                    ^ sph_pkg::rol64(z[r * 4 + ((j + 2) % 4)], sph_pkg::ROT_B[r])
                    ^ sph_pkg::rol64(z[r * 4 + ((j + 3) % 4)], sph_pkg::ROT_C[r])
                    ^ sph_pkg::rol64(z[r * 4 + j], sph_pkg::ROT_D[r]);
            end
        end
        x[0] = x[0] ^ i_rc;
        o_lanes = x;
    end

endmodule

// ===== hdl/sponge_hash_2048_absorb_squeeze.sv =====
// sponge hash top level: byte absorb, round sequencer and digest squeeze
// absorb: each message byte is XORed into the state as it is taken; a full block then runs a permutation
// final byte: one or two permutations (with an ST_PAD step for a full final byte),
// then 6 digest words at one per cycle when the sink is ready (or one error word)
// throughput: 1 byte per cycle inside a block, then intake stalls for the permutation of each full block
// reset: synchronous active low, state and byte position cleared, length register to 384
`timescale 1ns / 1ps

module sponge_hash_2048_absorb_squeeze #(
    parameter int RATE_BYTES  = 160,
    parameter int ROUND_COUNT = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_data,
    // message input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_msg_byte,
    input  logic [3:0]  i_bit_count,
    input  logic        i_is_last,
    // digest output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_is_last_word,
    output logic        o_status
);

    localparam int RND_W = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
    localparam logic [7:0]       POS_LAST  = 8'(RATE_BYTES - 1);
    localparam logic [RND_W-1:0] RND_LAST  = RND_W'(ROUND_COUNT - 1);
    localparam logic [2:0]       WORD_LAST = 3'(sph_pkg::DIGEST_WORDS - 1);

    // control and state registers
    sph_pkg::t_state  r_state, n_state;
    sph_pkg::t_after  r_after, n_after;
    logic [RND_W-1:0] r_rnd, n_rnd;
    logic [7:0]       r_pos, n_pos;
    logic [2:0]       r_word, n_word;
    logic [8:0]       r_cfg;
    sph_pkg::t_lanes  r_lanes, n_lanes;

    // output register
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_out_word, n_out_word;
    logic [2:0]  r_out_index, n_out_index;
    logic        r_out_last, n_out_last;
    logic        r_out_status, n_out_status;

    sph_pkg::t_lanes round_lanes;
    logic [7:0]      pad_mask;
    logic [7:0]      pad_bits;
    logic [7:0]      in_byte;
    logic            pos_at_end;
    logic            len_ok;
    logic            out_free;

    // shared round unit, one round per cycle
    sph_round u_round (
        .i_lanes (r_lanes),
        .i_rc    (sph_pkg::RC_TABLE[sph_pkg::RC_IDX_W'(r_rnd)]),
        .o_lanes (round_lanes)
    );

    assign pos_at_end = (r_pos == POS_LAST);
    assign len_ok     = ((r_cfg >> 3) == 9'(sph_pkg::DIGEST_BYTES));
    assign out_free   = !r_out_valid || i_out_ready;
    // partial final byte: keep the message bits, set the bit just after them
    assign pad_mask   = 8'hFF << (4'd8 - i_bit_count);
    assign pad_bits   = (i_msg_byte & pad_mask) | (sph_pkg::PAD_BYTE >> i_bit_count);

    assign o_in_ready = (r_state == sph_pkg::ST_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sph_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after     <= sph_pkg::AFT_NONE;
            r_rnd       <= '0;
            r_pos       <= '0;
            r_word      <= '0;
            r_cfg       <= sph_pkg::DIGEST_LEN_RESET;
            r_lanes     <= '{default: '0};
            r_out_valid <= 1'b0;
        end else begin
            r_after     <= n_after;
            r_rnd       <= n_rnd;
            r_pos       <= n_pos;
            r_word      <= n_word;
            r_lanes     <= n_lanes;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    // output payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_out_word   <= n_out_word;
        r_out_index  <= n_out_index;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
    end

    // next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_after      = r_after;
        n_rnd        = '0;
        n_pos        = r_pos;
        n_word       = r_word;
        n_lanes      = r_lanes;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_word   = r_out_word;
        n_out_index  = r_out_index;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;
        in_byte      = i_msg_byte;

        unique case (r_state)
            sph_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    // whole byte unless this is a short final byte
                    if (i_is_last && (i_bit_count < 4'd8)) begin
                        in_byte = pad_bits;
                    end
                    n_lanes[r_pos[7:3]] = r_lanes[r_pos[7:3]]
                                          ^ (64'(in_byte) << {r_pos[2:0], 3'b000});
                    if (!i_is_last) begin
                        if (pos_at_end) begin
                            n_pos   = '0;
                            n_after = sph_pkg::AFT_NONE;
                            n_state = sph_pkg::ST_PERM;
                        end else begin
                            n_pos = r_pos + 8'd1;
                        end
                    end else if (i_bit_count >= 4'd8) begin
                        // full final byte, pad byte goes in the next position
                        if (pos_at_end) begin
                            n_pos   = '0;
                            n_after = sph_pkg::AFT_PAD;
                            n_state = sph_pkg::ST_PERM;
                        end else begin
                            n_pos   = r_pos + 8'd1;
                            n_state = sph_pkg::ST_PAD;
                        end
                    end else begin
                        n_after = sph_pkg::AFT_SQUEEZE;
                        n_state = sph_pkg::ST_PERM;
                    end
                end
            end
            sph_pkg::ST_PAD: begin
                n_lanes[r_pos[7:3]] = r_lanes[r_pos[7:3]]
                                      ^ (64'(sph_pkg::PAD_BYTE) << {r_pos[2:0], 3'b000});
                n_after = sph_pkg::AFT_SQUEEZE;
                n_state = sph_pkg::ST_PERM;
            end
            sph_pkg::ST_PERM: begin
                n_lanes = round_lanes;
                n_rnd   = r_rnd + RND_W'(1);
                if (r_rnd == RND_LAST) begin
                    n_rnd = '0;
                    unique case (r_after)
                        sph_pkg::AFT_PAD: begin
                            n_state = sph_pkg::ST_PAD;
                        end
                        sph_pkg::AFT_SQUEEZE: begin
                            n_word  = '0;
                            n_state = sph_pkg::ST_OUT;
                        end
                        default: begin
                            n_state = sph_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            sph_pkg::ST_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (len_ok) begin
                        // lane 0 goes out, the rest shift down
                        n_out_word   = r_lanes[0];
                        n_out_index  = r_word;
                        n_out_last   = (r_word == WORD_LAST);
                        n_out_status = sph_pkg::STATUS_OK;
                        for (int i = 0; i < sph_pkg::LANE_COUNT - 1; i++) begin
                            n_lanes[i] = r_lanes[i + 1];
                        end
                        n_lanes[sph_pkg::LANE_COUNT - 1] = '0;
                        n_word = r_word + 3'd1;
                        if (r_word == WORD_LAST) begin
                            n_lanes = '{default: '0};
                            n_pos   = '0;
                            n_state = sph_pkg::ST_IDLE;
                        end
                    end else begin
                        // bad digest length: single error transfer
                        n_out_word   = '0;
                        n_out_index  = '0;
                        n_out_last   = 1'b1;
                        n_out_status = sph_pkg::STATUS_BAD_LEN;
                        n_lanes      = '{default: '0};
                        n_pos        = '0;
                        n_state      = sph_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = sph_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_digest_word  = r_out_word;
    assign o_word_index   = r_out_index;
    assign o_is_last_word = r_out_last;
    assign o_status       = r_out_status;

    // byte position never runs past the block
    a_pos_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LAST)
        else $error("byte position beyond block");

    // a mid-block byte leaves the block ready for the next transfer
    a_mid_block_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_is_last && !pos_at_end) |=> o_in_ready)
        else $error("intake stalled inside a block");

    // an ok last word always carries the final index
    a_last_word_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_last_word && (o_status == sph_pkg::STATUS_OK))
            |-> (o_word_index == WORD_LAST))
        else $error("last digest word with wrong index");

    // leaving the squeeze returns the byte position to zero
    a_squeeze_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == sph_pkg::ST_OUT) && (n_state == sph_pkg::ST_IDLE)) |=> (r_pos == 8'd0))
        else $error("byte position not cleared after squeeze");

endmodule
